[rtl/core/sliding_median_distance_filter_unit_defines.svh]
// Assertion macros for the sliding median distance filter.
`ifndef SLIDING_MEDIAN_DISTANCE_FILTER_UNIT_DEFINES_SVH
`define SLIDING_MEDIAN_DISTANCE_FILTER_UNIT_DEFINES_SVH

// Checked on clk_i, off while rst_ni is low.
`define SMDF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked on every rising edge of clk_i, reset included.
`define SMDF_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

[rtl/core/smdf_pkg.sv]
package smdf_pkg;

  localparam int MAX_WINDOW        = 7;
  localparam int VALID_BIT         = 0;
  localparam int FILTER_ACTIVE_BIT = 1;

  localparam int DIST_W   = 16;
  localparam int ECHO_W   = 32;
  localparam int HEALTH_W = 8;
  localparam int STAMP_W  = 32;
  localparam int WIN_W    = 3;
  localparam int CNT_W    = $clog2(MAX_WINDOW + 1);

  typedef logic signed [DIST_W-1:0] dist_t;
  typedef logic [CNT_W-1:0]         cnt_t;
  typedef dist_t                    sample_arr_t [MAX_WINDOW];

  localparam dist_t NO_READING = -16'sd1;

  typedef struct packed {
    logic start;
    cnt_t n;
  } med_req_t;

  typedef struct packed {
    logic  done;
    dist_t median;
  } med_rsp_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LAUNCH,
    S_WAIT,
    S_DONE
  } top_state_e;

  typedef enum logic [1:0] {
    M_IDLE,
    M_SCAN,
    M_CHECK
  } med_state_e;

endpackage

[rtl/core/smdf_median.sv]
`include "sliding_median_distance_filter_unit_defines.svh"

// Rank-count median over the first n samples using one comparator.
module smdf_median import smdf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  med_req_t    req_i,
  input  sample_arr_t samples_i,
  output med_rsp_t    rsp_o
);

  med_state_e  state_q, state_d;
  sample_arr_t wk_q, wk_d, wk_rot;
  dist_t       cand_q, cand_d;
  cnt_t        n_q, n_d;
  cnt_t        step_q, step_d;
  cnt_t        lt_q, lt_d;
  cnt_t        eq_q, eq_d;
  cnt_t        nm1;
  cnt_t        half;
  logic [CNT_W:0] lt_eq_sum;
  logic        is_lt, is_eq, found;

  assign nm1       = n_q - cnt_t'(1);
  assign half      = n_q >> 1;
  assign lt_eq_sum = {1'b0, lt_q} + {1'b0, eq_q};
  assign found     = (lt_q <= half) && ({1'b0, half} < lt_eq_sum);
  assign is_lt     = wk_q[0] < cand_q;
  assign is_eq     = wk_q[0] == cand_q;

  // rotate the first n entries by one
  always_comb begin
    for (int k = 0; k < MAX_WINDOW; k++) begin
      if (cnt_t'(k) == nm1) begin
        wk_rot[k] = wk_q[0];
      end else if (cnt_t'(k) < nm1) begin
        wk_rot[k] = wk_q[(k + 1) % MAX_WINDOW];
      end else begin
        wk_rot[k] = wk_q[k];
      end
    end
  end

  always_comb begin
    state_d = state_q;
    wk_d    = wk_q;
    cand_d  = cand_q;
    n_d     = n_q;
    step_d  = step_q;
    lt_d    = lt_q;
    eq_d    = eq_q;
    rsp_o.done   = 1'b0;
    rsp_o.median = cand_q;
    unique case (state_q)
      M_IDLE: begin
        if (req_i.start) begin
          wk_d    = samples_i;
          cand_d  = samples_i[0];
          n_d     = req_i.n;
          step_d  = '0;
          lt_d    = '0;
          eq_d    = '0;
          state_d = M_SCAN;
        end
      end
      M_SCAN: begin
        lt_d   = lt_q + cnt_t'(is_lt);
        eq_d   = eq_q + cnt_t'(is_eq);
        wk_d   = wk_rot;
        step_d = step_q + cnt_t'(1);
        if (step_q == nm1) begin
          state_d = M_CHECK;
        end
      end
      M_CHECK: begin
        if (found) begin
          rsp_o.done = 1'b1;
          state_d    = M_IDLE;
        end else begin
          wk_d    = wk_rot;
          cand_d  = wk_rot[0];
          step_d  = '0;
          lt_d    = '0;
          eq_d    = '0;
          state_d = M_SCAN;
        end
      end
      default: state_d = M_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= M_IDLE;
      n_q     <= '0;
      step_q  <= '0;
      lt_q    <= '0;
      eq_q    <= '0;
    end else begin
      state_q <= state_d;
      n_q     <= n_d;
      step_q  <= step_d;
      lt_q    <= lt_d;
      eq_q    <= eq_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wk_q   <= wk_d;
    cand_q <= cand_d;
  end

  `SMDF_ASSERT(a_start_idle, req_i.start |-> state_q == M_IDLE, "median start while busy")
  `SMDF_ASSERT(a_start_n, req_i.start |-> req_i.n != '0, "median start with empty window")
  `SMDF_ASSERT(a_step_range, state_q == M_SCAN |-> step_q < n_q, "scan ran past window")
  `SMDF_ASSERT(a_count_sum, state_q == M_CHECK |-> lt_eq_sum <= {1'b0, n_q},
               "rank counts exceed window")
  `SMDF_ASSERT(a_done_idle, rsp_o.done |=> state_q == M_IDLE, "median not idle after done")

endmodule

[rtl/core/sliding_median_distance_filter_unit.sv]
// Channel | Handshake                  | Payload
// in      | in_valid_i / in_stall_o    | raw_distance_i, echo_time_i, health_in_i, timestamp_i
// out     | out_valid_o / out_stall_i  | filtered_distance_o, raw_distance_out_o,
//         |                            | echo_time_out_o, health_out_o, timestamp_out_o
// cfg     | cfg_we_i                   | cfg_wdata_i (window_size)
//
// Unstored sample: S_IDLE goes straight to S_DONE, where the result is ready.
// Stored sample: passes S_LAUNCH, S_WAIT and S_DONE, with c <= n candidates
// (n = samples in window) ranked by the shared comparator in smdf_median before the median is found.
// in_stall_o is high while a sample is in work or a finished one waits for the
// output register; one result is held while out_stall_i is high.
// Reset: empty window, window_size 1; sample line contents undefined.
module sliding_median_distance_filter_unit import smdf_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [WIN_W-1:0]    cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic signed [DIST_W-1:0] raw_distance_i,
  input  logic [ECHO_W-1:0]   echo_time_i,
  input  logic [HEALTH_W-1:0] health_in_i,
  input  logic [STAMP_W-1:0]  timestamp_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic signed [DIST_W-1:0] filtered_distance_o,
  output logic signed [DIST_W-1:0] raw_distance_out_o,
  output logic [ECHO_W-1:0]   echo_time_out_o,
  output logic [HEALTH_W-1:0] health_out_o,
  output logic [STAMP_W-1:0]  timestamp_out_o
);

  top_state_e        state_q, state_d;
  logic [WIN_W-1:0]  window_q, window_d;
  cnt_t              fill_q, fill_d;
  sample_arr_t       sh_q;
  logic              out_valid_q, out_valid_d;

  dist_t             raw_q, filt_q;
  logic [ECHO_W-1:0] echo_q;
  logic [HEALTH_W-1:0] health_q;
  logic [STAMP_W-1:0] stamp_q;

  logic              in_xfer, store, win_ok, load_out, set_filt;
  dist_t             filt_d;
  logic [HEALTH_W-1:0] health_mark;
  med_req_t          med_req;
  med_rsp_t          med_rsp;

  assign in_xfer = in_valid_i && !in_stall_o;
  assign store   = health_in_i[VALID_BIT] && !raw_distance_i[DIST_W-1];
  assign win_ok  = cfg_wdata_i[0] && (int'(cfg_wdata_i) <= MAX_WINDOW);

  always_comb begin
    health_mark = health_in_i;
    if (window_q > WIN_W'(1)) begin
      health_mark[FILTER_ACTIVE_BIT] = 1'b1;
    end
  end

  always_comb begin
    state_d     = state_q;
    in_stall_o  = 1'b1;
    load_out    = 1'b0;
    set_filt    = 1'b0;
    filt_d      = NO_READING;
    med_req.start = 1'b0;
    med_req.n     = fill_q;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          set_filt = 1'b1;
          state_d  = store ? S_LAUNCH : S_DONE;
        end
      end
      S_LAUNCH: begin
        med_req.start = 1'b1;
        state_d       = S_WAIT;
      end
      S_WAIT: begin
        if (med_rsp.done) begin
          set_filt = 1'b1;
          filt_d   = med_rsp.median;
          state_d  = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          load_out    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    window_d = window_q;
    fill_d   = fill_q;
    if (in_xfer && store && (fill_q < cnt_t'(window_q))) begin
      fill_d = fill_q + cnt_t'(1);
    end
    if (cfg_we_i && win_ok && (cfg_wdata_i != window_q)) begin
      window_d = cfg_wdata_i;
      fill_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      window_q    <= WIN_W'(1);
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      window_q    <= window_d;
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
    end
  end

  // newest sample at index 0
  always_ff @(posedge clk_i) begin
    if (in_xfer && store) begin
      sh_q[0] <= raw_distance_i;
      for (int k = 1; k < MAX_WINDOW; k++) begin
        sh_q[k] <= sh_q[k-1];
      end
    end
    if (in_xfer) begin
      raw_q    <= raw_distance_i;
      echo_q   <= echo_time_i;
      health_q <= health_mark;
      stamp_q  <= timestamp_i;
    end
    if (set_filt) begin
      filt_q <= filt_d;
    end
    if (load_out) begin
      filtered_distance_o <= filt_q;
      raw_distance_out_o  <= raw_q;
      echo_time_out_o     <= echo_q;
      health_out_o        <= health_q;
      timestamp_out_o     <= stamp_q;
    end
  end

  assign out_valid_o = out_valid_q;

  smdf_median u_median (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (med_req),
    .samples_i (sh_q),
    .rsp_o     (med_rsp)
  );

endmodule
